// ===== src/hmt3_pkg.sv =====
// ----------------------------------------------------------------------------
// hmt3_pkg
// Shared types and constants of the 3x3 hit-or-miss transform: register
// indexes, structuring element masks and the result record.
// ----------------------------------------------------------------------------
package hmt3_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_ELEMENT_SELECT = 2'd2;

  localparam logic [7:0] HIT_VALUE  = 8'd0;
  localparam logic [7:0] MISS_VALUE = 8'd255;

  // window entry i = (dx+1)*3 + (dy+1); a set care bit means the entry is
  // matched, a set high bit means it must equal 255, otherwise 0
  localparam logic [8:0] ELEM_CARE [4] = '{9'h059, 9'h017, 9'h134, 9'h1D0};
  localparam logic [8:0] ELEM_HIGH [4] = '{9'h010, 9'h010, 9'h010, 9'h010};

  typedef struct packed {
    logic       last;
    logic [7:0] value;
    logic [11:0] y;
    logic [9:0] x;
  } result_t;

  // up to three results caused by one pixel, in output order
  typedef struct packed {
    logic [2:0]    vld;
    result_t [2:0] res;
  } push_t;

  function automatic logic elem_hit(input logic [1:0] sel, input logic [8:0] eq_zero,
                                    input logic [8:0] eq_full);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 9; i++) begin
      if (ELEM_CARE[sel][i]) begin
        ok = ok & (ELEM_HIGH[sel][i] ? eq_full[i] : eq_zero[i]);
      end
    end
    return ok;
  endfunction

endpackage

// ===== src/hmt3_line_ram.sv =====
// ----------------------------------------------------------------------------
// hmt3_line_ram
// Simple dual-port line store: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module hmt3_line_ram #(
  parameter int Depth = 1024,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/hmt3_result_buf.sv =====
// ----------------------------------------------------------------------------
// hmt3_result_buf
// Output stage: holds the results of one pixel and sends them one per
// request on the master stream, lowest slot first.
// ----------------------------------------------------------------------------
module hmt3_result_buf
  import hmt3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  push_t       push_i,
  output logic        room_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_x[9:0], out_y[21:10], value[29:22], zero pad
  output logic        m_axis_tlast   // last
);

  result_t    slot_q [3];
  logic [2:0] vld_q, vld_d;
  logic [2:0] sel, take;
  result_t    cur;

  // lowest pending slot goes out first
  assign sel  = vld_q & ~(vld_q - 3'd1);
  assign take = (m_axis_tvalid && m_axis_tready) ? sel : 3'b000;
  assign room_o = (vld_q & ~take) == 3'b000;

  always_comb begin
    priority if (vld_q[0]) begin
      cur = slot_q[0];
    end else if (vld_q[1]) begin
      cur = slot_q[1];
    end else begin
      cur = slot_q[2];
    end
  end

  always_comb begin
    vld_d = load_i ? push_i.vld : (vld_q & ~take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 3'b000;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < 3; i++) begin
        slot_q[i] <= push_i.res[i];
      end
    end
  end

  assign m_axis_tvalid = |vld_q;
  assign m_axis_tdata  = {2'b00, cur.value, cur.y, cur.x};
  assign m_axis_tlast  = cur.last;

  a_load_only_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (vld_q & ~take) == 3'b000)
    else $error("result slots overwritten before sent");

endmodule

// ===== src/hit_or_miss_transform_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// hit_or_miss_transform_3x3_unit
// 3x3 hit-or-miss transform over a raster pixel stream with two line stores
// in one synchronous memory and a selectable fixed structuring element.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  s_axis    in   tdata[7:0] pixel                          tvalid/tready
//  m_axis    out  tdata x[9:0] y[21:10] value[29:22], tlast tvalid/tready
//  cfg       in   cfg_addr_i index, cfg_wdata_i value       cfg_we_i
//
//  one pixel per cycle while the result port keeps up: a pixel is read from
//  the line memory in its accept cycle and written back with the window
//  update when it leaves the second stage. row-end pixels below row 0 and
//  last-row pixels past column 0 give two results, the last pixel of a frame
//  three; there the single result port sets the pace, one result at a time.
//  reset clears counters, window and control; the line memory is not cleared.
//  a stalled output holds the pixel in the second stage and drops s_axis_tready.
// ----------------------------------------------------------------------------
module hit_or_miss_transform_3x3_unit
  import hmt3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_x[9:0], out_y[21:10], value[29:22], zero pad
  output logic        m_axis_tlast,   // last
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [11:0] cfg_wdata_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int PB = PIXEL_BITS;

  // configuration
  logic [10:0] frame_width_q;
  logic [11:0] frame_height_q;
  logic [1:0]  elem_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 11'd640;
      frame_height_q <= 12'd480;
      elem_sel_q     <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FRAME_WIDTH:    frame_width_q  <= cfg_wdata_i[10:0];
        REG_FRAME_HEIGHT:   frame_height_q <= cfg_wdata_i;
        REG_ELEMENT_SELECT: elem_sel_q     <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [WW-1:0] fw_ext, width;
  logic [CW-1:0] wlast;
  logic [11:0]   hlast;

  always_comb begin
    fw_ext = WW'(frame_width_q);
    if (fw_ext < WW'(3)) begin
      width = WW'(3);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = fw_ext;
    end
    wlast = CW'(width - WW'(1));
    hlast = (frame_height_q < 12'd3) ? 12'd2 : frame_height_q - 12'd1;
  end

  // stage 0: position and memory read
  logic [CW-1:0] col_q, col_d, c_eff;
  logic [11:0]   row_q, row_d, r_eff;
  logic          accept;

  logic          s1_valid_q, s1_valid_d, s1_fire;
  logic [PB-1:0] s1_pix_q;
  logic [CW-1:0] s1_col_q;
  logic [11:0]   s1_row_q;
  logic          s1_f1_q, s1_f2_q, s1_f3_q, s1_inner_q;
  logic          room;

  assign s1_fire       = s1_valid_q && room;
  assign s_axis_tready = !s1_valid_q || room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    c_eff = (col_q > wlast) ? '0 : col_q;
    r_eff = (row_q > hlast) ? 12'd0 : row_q;
    if (c_eff == wlast) begin
      col_d = '0;
      row_d = (r_eff == hlast) ? 12'd0 : r_eff + 12'd1;
    end else begin
      col_d = c_eff + CW'(1);
      row_d = r_eff;
    end
    s1_valid_d = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= 12'd0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= PB'(s_axis_tdata);
      s1_col_q   <= c_eff;
      s1_row_q   <= r_eff;
      s1_f1_q    <= (r_eff != 12'd0) && (c_eff != '0);
      s1_f2_q    <= (r_eff != 12'd0) && (c_eff == wlast);
      s1_f3_q    <= r_eff == hlast;
      s1_inner_q <= (r_eff >= 12'd2) && (c_eff >= CW'(2));
    end
  end

  // line memory: upper half holds two rows back, lower half one row back
  logic [2*PB-1:0] ram_rdata;
  logic [PB-1:0]   two_back, one_back;

  hmt3_line_ram #(
    .Depth (MAX_WIDTH),
    .Width (2 * PB)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i ({one_back, s1_pix_q}),
    .re_i    (accept),
    .raddr_i (c_eff),
    .rdata_o (ram_rdata)
  );

  assign two_back = ram_rdata[2*PB-1:PB];
  assign one_back = ram_rdata[PB-1:0];

  // stage 1: window update and match
  logic [PB-1:0] win_q [9];
  logic [PB-1:0] win_n [9];
  logic [8:0]    eq_zero, eq_full;
  logic          hit;
  logic [7:0]    match_val;
  push_t         push;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_n[i] = win_q[i+3];
    end
    win_n[6] = two_back;
    win_n[7] = one_back;
    win_n[8] = s1_pix_q;
    for (int i = 0; i < 9; i++) begin
      eq_zero[i] = win_n[i] == '0;
      eq_full[i] = 16'(win_n[i]) == 16'(MISS_VALUE);
    end
    hit       = elem_hit(elem_sel_q, eq_zero, eq_full);
    match_val = hit ? HIT_VALUE : MISS_VALUE;

    push.vld = {s1_f3_q, s1_f2_q, s1_f1_q};

    push.res[0].x     = 10'(s1_col_q - CW'(1));
    push.res[0].y     = s1_row_q - 12'd1;
    push.res[0].value = s1_inner_q ? match_val : 8'(win_n[4]);
    push.res[0].last  = !s1_f2_q && !s1_f3_q;

    push.res[1].x     = 10'(wlast);
    push.res[1].y     = s1_row_q - 12'd1;
    push.res[1].value = 8'(win_n[7]);
    push.res[1].last  = !s1_f3_q;

    push.res[2].x     = 10'(s1_col_q);
    push.res[2].y     = s1_row_q;
    push.res[2].value = 8'(s1_pix_q);
    push.res[2].last  = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_n[i];
      end
    end
  end

  hmt3_result_buf u_result_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s1_fire),
    .push_i        (push),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // a new pixel's read and the previous pixel's write-back never share a column
  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_fire) |-> (c_eff != s1_col_q))
    else $error("line memory read and write at same column");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i) |=> (col_q <= wlast))
    else $error("column count beyond row width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i) |=> (row_q <= hlast))
    else $error("row count beyond frame height");

endmodule

// ===== tb/hmt3_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hmt3_result_checker
// Watches the pixel, result and register channels of the 3x3 hit-or-miss
// unit. Each accepted pixel is run through a local model of the line stores
// and the window, and the results it causes are queued. Each accepted result
// is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module hmt3_result_checker
  import hmt3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel[7:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // out_x[9:0], out_y[21:10], value[29:22], zero pad
  input  logic        m_axis_tlast,   // last
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [11:0] cfg_wdata_i,
  output int          mismatch_count_o,
  output int          results_pending_o
);

  // window positions that each element checks, entry i = (dx+1)*3 + (dy+1);
  // every element wants 255 at the center and 0 at its other checked entries
  localparam logic [3:0][8:0] ELEMENT_CARE = {9'h1D0, 9'h134, 9'h017, 9'h059};
  localparam int CENTER = 4;
  localparam int PRINT_LIMIT = 40;

  logic [10:0] frame_width_q;
  logic [11:0] frame_height_q;
  logic [1:0]  element_q;
  logic [7:0]  row_above2 [MAX_WIDTH];
  logic [7:0]  row_above1 [MAX_WIDTH];
  logic [7:0]  win [9];
  int          col_pos;
  int          row_pos;
  result_t     expected_results [$];
  int          mismatch_count;

  assign mismatch_count_o  = mismatch_count;
  assign results_pending_o = expected_results.size();

  task automatic report_mismatch(input string msg);
    // keep the log short if the block is badly broken
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic result_t make_result(input int x, input int y, input logic [7:0] v);
    result_t res;
    res.x     = 10'(x);
    res.y     = 12'(y);
    res.value = v;
    res.last  = 1'b0;
    return res;
  endfunction

  function automatic logic [7:0] window_match();
    logic [7:0] want;
    for (int i = 0; i < 9; i++) begin
      want = (i == CENTER) ? 8'd255 : 8'd0;
      if (ELEMENT_CARE[element_q][i] && win[i] != want) begin
        return MISS_VALUE;
      end
    end
    return HIT_VALUE;
  endfunction

  task automatic predict_pixel(input logic [7:0] px);
    int         w;
    int         h;
    int         c;
    int         r;
    int         n;
    logic [7:0] above2;
    logic [7:0] above1;
    result_t    res [3];
    w = frame_width_q;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = frame_height_q;
    if (h < 3) h = 3;
    // a size change in mid-frame restarts the row or the frame
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;

    above2 = row_above2[c];
    above1 = row_above1[c];
    for (int i = 0; i < 6; i++) win[i] = win[i + 3];
    win[6] = above2;
    win[7] = above1;
    win[8] = px;
    row_above2[c] = above1;
    row_above1[c] = px;

    n = 0;
    if (r >= 1 && c >= 1) begin
      res[n] = make_result(c - 1, r - 1, (c >= 2 && r >= 2) ? window_match() : win[4]);
      n++;
    end
    // right border pixel of the row above
    if (r >= 1 && c == w - 1) begin
      res[n] = make_result(w - 1, r - 1, win[7]);
      n++;
    end
    // bottom row goes straight through
    if (r == h - 1) begin
      res[n] = make_result(c, r, px);
      n++;
    end
    for (int k = 0; k < n; k++) begin
      res[k].last = (k == n - 1);
      expected_results.push_back(res[k]);
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic check_result();
    result_t    want;
    logic [9:0] got_x;
    logic [11:0] got_y;
    logic [7:0] got_v;
    got_x = m_axis_tdata[9:0];
    got_y = m_axis_tdata[21:10];
    got_v = m_axis_tdata[29:22];
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result x=%0d y=%0d value=%0d", got_x, got_y,
                                got_v));
    end else begin
      want = expected_results.pop_front();
      if (got_x !== want.x)
        report_mismatch($sformatf("out_x got %0d want %0d (y %0d)", got_x, want.x, want.y));
      if (got_y !== want.y)
        report_mismatch($sformatf("out_y got %0d want %0d (x %0d)", got_y, want.y, want.x));
      if (got_v !== want.value)
        report_mismatch($sformatf("value got %0d want %0d at %0d,%0d", got_v, want.value,
                                  want.x, want.y));
      if (m_axis_tlast !== want.last)
        report_mismatch($sformatf("tlast got %b want %b at %0d,%0d", m_axis_tlast, want.last,
                                  want.x, want.y));
      if (m_axis_tdata[31:30] !== 2'b00)
        report_mismatch($sformatf("tdata pad bits not zero at %0d,%0d", want.x, want.y));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  = 11'd640;
      frame_height_q = 12'd480;
      element_q      = 2'd0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above2[i] = 8'd0;
        row_above1[i] = 8'd0;
      end
      for (int i = 0; i < 9; i++) win[i] = 8'd0;
      col_pos = 0;
      row_pos = 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_FRAME_WIDTH:    frame_width_q  = cfg_wdata_i[10:0];
          REG_FRAME_HEIGHT:   frame_height_q = cfg_wdata_i;
          REG_ELEMENT_SELECT: element_q      = cfg_wdata_i[1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
  end

  initial mismatch_count = 0;

endmodule

// ===== tb/hit_or_miss_transform_3x3_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hit_or_miss_transform_3x3_unit_tb
// Drives pixel frames into the 3x3 hit-or-miss unit: hand-built frames with
// a zero side column, a frame that fills the line stores, size changes
// in mid-frame, then random frames under several sender and receiver idle
// mixes with one long receiver hold-off. Results are checked by the checker.
// ----------------------------------------------------------------------------
module hit_or_miss_transform_3x3_unit_tb;
  import hmt3_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT_NS  = 2000000;

  // raster-order 3x3 frames: left column zero with a full center, and right
  // column zero with a full center
  localparam logic [0:8][7:0] LEFT_HIT_FRAME =
    {8'd0, 8'hAA, 8'd5, 8'd0, 8'd255, 8'd255, 8'd0, 8'h55, 8'd255};
  localparam logic [0:8][7:0] RIGHT_HIT_FRAME =
    {8'd255, 8'd128, 8'd0, 8'd1, 8'd255, 8'd0, 8'd254, 8'd127, 8'd0};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_addr_i    = REG_FRAME_WIDTH;
  logic [11:0] cfg_wdata_i   = 12'd0;

  int mismatch_total;
  int results_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  hit_or_miss_transform_3x3_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  hmt3_result_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tlast      (m_axis_tlast),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mismatch_count_o  (mismatch_total),
    .results_pending_o (results_pending)
  );

  // result side: random stalls, plus a long hold-off whenever one is asked for
  always @(posedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served   <= hold_asked;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // mostly 0 and 255 so that the elements actually hit now and then
  function automatic logic [7:0] random_pixel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 8'd0;
    if (roll < 80) return 8'd255;
    if (roll < 85) return 8'd5;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [7:0] px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic configure_frame(input logic [10:0] width, input logic [11:0] height,
                                 input logic [1:0] elem);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_FRAME_WIDTH;
    cfg_wdata_i <= {1'b0, width};
    @(posedge clk_i);
    cfg_addr_i  <= REG_FRAME_HEIGHT;
    cfg_wdata_i <= height;
    @(posedge clk_i);
    cfg_addr_i  <= REG_ELEMENT_SELECT;
    cfg_wdata_i <= {10'd0, elem};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // pixels of the first row give no result, so allow the pipe to settle too
  task automatic wait_idle();
    int waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (results_pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int items,
                                  input bit with_hold);
    int sent;
    int w_reg;
    int h_reg;
    int area;
    int burst;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      // register values below 3 are clamped by the block
      w_reg = $urandom_range(0, 9);
      h_reg = $urandom_range(0, 6);
      configure_frame(11'(w_reg), 12'(h_reg), 2'($urandom_range(0, 3)));
      area = ((w_reg < 3) ? 3 : w_reg) * ((h_reg < 3) ? 3 : h_reg);
      // some frames stop early so the next sizes land in mid-frame
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(1, area - 1) : area;
      if (with_hold && sent == 0) hold_asked++;
      send_random(burst);
      sent += burst;
      wait_idle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-built frames, undersized registers clamp to 3x3
    configure_frame(11'd0, 12'd2, 2'd0);
    for (int i = 0; i < 9; i++) send_pixel(LEFT_HIT_FRAME[i]);
    wait_idle();
    configure_frame(11'd3, 12'd1, 2'd3);
    for (int i = 0; i < 9; i++) send_pixel(RIGHT_HIT_FRAME[i]);
    wait_idle();

    // ten-wide frame writes both line stores at every column later frames use
    configure_frame(11'd10, 12'd3, 2'd2);
    send_random(30);
    wait_idle();

    // size changes in mid-frame
    configure_frame(11'd6, 12'd5, 2'd2);
    send_random(17);
    wait_idle();
    // column beyond the new width: row restarts at column 0
    configure_frame(11'd4, 12'd3, 2'd1);
    send_random(6);
    wait_idle();
    // width grows inside the frame
    configure_frame(11'd8, 12'd5, 2'd3);
    send_random(25);
    wait_idle();
    // row beyond the new height: frame restarts at row 0
    configure_frame(11'd8, 12'd3, 2'd0);
    send_random(21);
    wait_idle();

    run_random_phase(0, 0, 55, 1'b1);
    run_random_phase(87, 0, 55, 1'b0);
    run_random_phase(0, 87, 55, 1'b0);
    run_random_phase(36, 36, 55, 1'b0);

    if (mismatch_total == 0 && results_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
